FILE: sv/dtg_pkg.sv
package dtg_pkg;

	// field widths
	localparam int CFG_W     = 18;
	localparam int REG_IDX_W = 2;
	localparam int LEN_W     = 7;
	localparam int SAMPLE_W  = 8;
	localparam int TERM_W    = 9;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TONE_ONE    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TONE_TWO    = 2'd2;

	localparam logic [CFG_W-1:0] SAMPLE_RATE_RST = 18'd44100;
	localparam logic [CFG_W-1:0] TONE_ONE_RST    = 18'd1000;
	localparam logic [CFG_W-1:0] TONE_TWO_RST    = 18'd5000;

	localparam int MAX_BURST_DEF = 64;
	localparam int AMPLITUDE_DEF = 150;

	// divider: 2 quotient bits per step over a 34-bit dividend window
	localparam int DVD_W  = 2 * CFG_W - 2;
	localparam int DCNT_W = 5;
	localparam logic [DCNT_W-1:0] DIV_STEPS_PERIOD = DCNT_W'(CFG_W / 2);
	localparam logic [DCNT_W-1:0] DIV_STEPS_TURN   = DCNT_W'(DVD_W / 2);
	localparam logic [DCNT_W-1:0] DIV_STEPS_MOD    = DCNT_W'((CFG_W + 2) / 2);

	// sine polynomial coefficients, Q15
	localparam logic [15:0] SIN_C1 = 16'd51472;
	localparam logic [15:0] SIN_C3 = 16'd21167;
	localparam logic [15:0] SIN_C5 = 16'd2611;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_PER_DIV,
		OP_DIV_STEP,
		OP_PER_WB,
		OP_TURN_DIV,
		OP_SIN_SETUP,
		OP_MUL_ZZ,
		OP_MUL_Z2C5,
		OP_SUB_C3,
		OP_MUL_Z2T,
		OP_SUB_C1,
		OP_MUL_ZT,
		OP_CAP,
		OP_MUL_AMP,
		OP_TERM,
		OP_EMIT,
		OP_ADV_TRY,
		OP_MOD_DIV,
		OP_MOD_WB,
		OP_NEXT,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_START,
		C_DIV_MORE,
		C_OUT_BUSY,
		C_ALL_OK,
		C_MORE
	} cond_t;

	localparam int PC_W = 5;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic start;
		logic div_more;
		logic out_busy;
		logic all_ok;
		logic more;
	} seq_stat_t;

	// program addresses
	localparam logic [PC_W-1:0] P_IDLE     = 5'd0;
	localparam logic [PC_W-1:0] P_PER_WAIT = 5'd2;
	localparam logic [PC_W-1:0] P_SAMPLE   = 5'd4;
	localparam logic [PC_W-1:0] P_TURN_WAIT = 5'd5;
	localparam logic [PC_W-1:0] P_EMIT     = 5'd16;
	localparam logic [PC_W-1:0] P_MOD_WAIT = 5'd19;
	localparam logic [PC_W-1:0] P_LOOP     = 5'd21;

	function automatic ucode_t ucw(input op_t op, input cond_t cond,
			input logic [PC_W-1:0] target);
		ucode_t w;
		w.op = op;
		w.cond = cond;
		w.target = target;
		return w;
	endfunction

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			5'd0:  w = ucw(OP_IDLE,      C_NO_START, P_IDLE);
			5'd1:  w = ucw(OP_PER_DIV,   C_NEXT,     P_IDLE);
			5'd2:  w = ucw(OP_DIV_STEP,  C_DIV_MORE, P_PER_WAIT);
			5'd3:  w = ucw(OP_PER_WB,    C_NEXT,     P_IDLE);
			5'd4:  w = ucw(OP_TURN_DIV,  C_NEXT,     P_IDLE);
			5'd5:  w = ucw(OP_DIV_STEP,  C_DIV_MORE, P_TURN_WAIT);
			5'd6:  w = ucw(OP_SIN_SETUP, C_NEXT,     P_IDLE);
			5'd7:  w = ucw(OP_MUL_ZZ,    C_NEXT,     P_IDLE);
			5'd8:  w = ucw(OP_MUL_Z2C5,  C_NEXT,     P_IDLE);
			5'd9:  w = ucw(OP_SUB_C3,    C_NEXT,     P_IDLE);
			5'd10: w = ucw(OP_MUL_Z2T,   C_NEXT,     P_IDLE);
			5'd11: w = ucw(OP_SUB_C1,    C_NEXT,     P_IDLE);
			5'd12: w = ucw(OP_MUL_ZT,    C_NEXT,     P_IDLE);
			5'd13: w = ucw(OP_CAP,       C_NEXT,     P_IDLE);
			5'd14: w = ucw(OP_MUL_AMP,   C_NEXT,     P_IDLE);
			5'd15: w = ucw(OP_TERM,      C_NEXT,     P_IDLE);
			5'd16: w = ucw(OP_EMIT,      C_OUT_BUSY, P_EMIT);
			5'd17: w = ucw(OP_ADV_TRY,   C_ALL_OK,   P_LOOP);
			5'd18: w = ucw(OP_MOD_DIV,   C_NEXT,     P_IDLE);
			5'd19: w = ucw(OP_DIV_STEP,  C_DIV_MORE, P_MOD_WAIT);
			5'd20: w = ucw(OP_MOD_WB,    C_NEXT,     P_IDLE);
			5'd21: w = ucw(OP_NEXT,      C_MORE,     P_SAMPLE);
			default: w = ucw(OP_NOP,     C_ALWAYS,   P_IDLE);
		endcase
		return w;
	endfunction

endpackage

FILE: sv/dtg_seq.sv
module dtg_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  dtg_pkg::seq_stat_t stat,
	output dtg_pkg::op_t      op
);
	import dtg_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	ucode_t          uw;
	logic            take;

	always_comb begin
		uw = ucode_rom(pc_q);
		unique case (uw.cond)
			C_NEXT:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_START: take = !stat.start;
			C_DIV_MORE: take = stat.div_more;
			C_OUT_BUSY: take = stat.out_busy;
			C_ALL_OK:   take = stat.all_ok;
			C_MORE:     take = stat.more;
			default:    take = 1'b0;
		endcase
		pc_d = take ? uw.target : pc_q + PC_W'(1);
	end

	assign op = uw.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

FILE: sv/dtg_lane.sv
module dtg_lane #(
	parameter int AMPLITUDE = dtg_pkg::AMPLITUDE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dtg_pkg::op_t                      op,
	input  logic [dtg_pkg::CFG_W-1:0]         sample_rate,
	input  logic [dtg_pkg::CFG_W-1:0]         freq,
	output logic                              fit,
	output logic signed [dtg_pkg::TERM_W-1:0] term
);
	import dtg_pkg::*;

	logic [CFG_W-1:0] phase_q;
	logic [CFG_W-1:0] period_q;
	logic             ok_q;

	// divider state
	logic [DVD_W-1:0] dvd_q;
	logic [CFG_W-1:0] dsr_q;
	logic [CFG_W:0]   rem_q;
	logic [CFG_W-1:0] quo_q;

	// sine datapath
	logic [15:0]             z_q;
	logic [15:0]             z2_q;
	logic [15:0]             t_q;
	logic [31:0]             prod_q;
	logic                    neg_q;
	logic signed [TERM_W-1:0] term_q;

	logic [CFG_W:0] inc;
	logic [CFG_W:0] dif;
	logic           fit1;
	logic           fit2;

	logic [CFG_W:0] r1;
	logic [CFG_W:0] r1s;
	logic           q1;
	logic [CFG_W:0] r2;
	logic [CFG_W:0] r2s;
	logic           q2;

	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [14:0] rr;
	logic [7:0]  mag;

	// phase advance, fast path covers a phase at most one period too far
	always_comb begin
		inc  = {1'b0, phase_q} + (CFG_W+1)'(1);
		fit1 = inc < {1'b0, period_q};
		dif  = inc - {1'b0, period_q};
		fit2 = dif < {1'b0, period_q};
	end
	assign fit = fit1 || fit2;

	// two restoring steps per cycle
	always_comb begin
		r1  = {rem_q[CFG_W-1:0], dvd_q[DVD_W-1]};
		q1  = r1 >= {1'b0, dsr_q};
		r1s = q1 ? r1 - {1'b0, dsr_q} : r1;
		r2  = {r1s[CFG_W-1:0], dvd_q[DVD_W-2]};
		q2  = r2 >= {1'b0, dsr_q};
		r2s = q2 ? r2 - {1'b0, dsr_q} : r2;
	end

	always_comb begin
		unique case (op)
			OP_MUL_ZZ: begin
				mul_a = z_q;
				mul_b = z_q;
			end
			OP_MUL_Z2C5: begin
				mul_a = prod_q[30:15];
				mul_b = SIN_C5;
			end
			OP_MUL_Z2T: begin
				mul_a = z2_q;
				mul_b = t_q;
			end
			OP_MUL_ZT: begin
				mul_a = z_q;
				mul_b = t_q;
			end
			OP_MUL_AMP: begin
				mul_a = t_q;
				mul_b = 16'(AMPLITUDE);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// odd quadrants fold back toward the peak
	always_comb begin
		if (quo_q[14]) begin
			rr = 15'h4000 - {1'b0, quo_q[13:0]};
		end else begin
			rr = {1'b0, quo_q[13:0]};
		end
		mag = prod_q[22:15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else begin
			unique case (op)
				OP_ADV_TRY: begin
					if (fit1) begin
						phase_q <= inc[CFG_W-1:0];
					end else if (fit2) begin
						phase_q <= dif[CFG_W-1:0];
					end
				end
				OP_MOD_WB: phase_q <= rem_q[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_PER_DIV: begin
				dvd_q <= {sample_rate, 16'd0};
				dsr_q <= freq;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_TURN_DIV: begin
				dvd_q <= {phase_q, 16'd0};
				dsr_q <= period_q;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_MOD_DIV: begin
				dvd_q <= {1'b0, (ok_q ? {1'b0, phase_q} : inc), 14'd0};
				dsr_q <= period_q;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				dvd_q <= {dvd_q[DVD_W-3:0], 2'b00};
				rem_q <= r2s;
				quo_q <= {quo_q[CFG_W-3:0], q1, q2};
			end
			OP_PER_WB: begin
				if (freq == '0 || quo_q == '0) begin
					period_q <= CFG_W'(1);
				end else begin
					period_q <= quo_q;
				end
			end
			OP_ADV_TRY: ok_q <= fit1 || fit2;
			OP_SIN_SETUP: begin
				z_q   <= {rr, 1'b0};
				neg_q <= quo_q[15];
			end
			OP_MUL_ZZ, OP_MUL_Z2T, OP_MUL_ZT, OP_MUL_AMP: prod_q <= mul_a * mul_b;
			OP_MUL_Z2C5: begin
				z2_q   <= prod_q[30:15];
				prod_q <= mul_a * mul_b;
			end
			OP_SUB_C3: t_q <= SIN_C3 - prod_q[30:15];
			OP_SUB_C1: t_q <= SIN_C1 - prod_q[30:15];
			OP_CAP: begin
				if (prod_q[31:15] > 17'd32767) begin
					t_q <= 16'h7FFF;
				end else begin
					t_q <= prod_q[30:15];
				end
			end
			OP_TERM: begin
				if (neg_q) begin
					term_q <= -$signed({1'b0, mag});
				end else begin
					term_q <= $signed({1'b0, mag});
				end
			end
			default: ;
		endcase
	end

	assign term = term_q;

endmodule

FILE: sv/dual_tone_generator.sv
// dual tone generator: signed 8-bit samples, the saturated sum of two sine tones
//
// input channel (in_valid / in_ready, burst_length): one transfer asks for a
// burst of samples; bursts above MAX_BURST are cut to MAX_BURST, a zero burst
// is taken and produces nothing
// output channel (out_valid / out_ready, sample, last): one transfer per sample,
// last marks the final sample of the burst
// config port (cfg_en, cfg_index, cfg_data): single-cycle writes of sample rate
// and the two tone frequencies, by the user only while no burst is in flight;
// the block itself does not enforce it
// sequencing: a microcoded sequencer steps two tone lanes in lockstep. a burst
// starts with the period division (two bits a cycle); each sample then takes
// the phase-to-turn division, the sine polynomial on one 16x16 multiplier per
// lane, then output, phase advance and loop; a further division runs when a
// phase has to be fully reduced after a frequency change, and a final step
// returns the sequencer to idle after the last sample.
// in_ready is high only while the sequencer sits at its idle step.
// output: a single output register; the sequencer keeps working on the next
// sample while it waits and holds at the emit step when the receiver stalls
// reset: registers return to 44100 / 1000 / 5000 Hz, both phases to zero
module dual_tone_generator #(
	parameter int MAX_BURST = dtg_pkg::MAX_BURST_DEF,
	parameter int AMPLITUDE = dtg_pkg::AMPLITUDE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dtg_pkg::LEN_W-1:0]         burst_length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [dtg_pkg::SAMPLE_W-1:0] sample,
	output logic                              last,
	input  logic                              cfg_en,
	input  logic [dtg_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [dtg_pkg::CFG_W-1:0]         cfg_data
);
	import dtg_pkg::*;

	localparam int CNT_W = $clog2(MAX_BURST + 1);

	// configuration registers
	logic [CFG_W-1:0] sample_rate_q;
	logic [CFG_W-1:0] tone_one_q;
	logic [CFG_W-1:0] tone_two_q;

	// sequencer control
	op_t              op;
	seq_stat_t        stat;
	logic [CNT_W-1:0] burst_cnt_q;
	logic [DCNT_W-1:0] div_cnt_q;

	// lanes
	logic                     fit_one;
	logic                     fit_two;
	logic signed [TERM_W-1:0] term_one;
	logic signed [TERM_W-1:0] term_two;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;

	logic                       start;
	logic                       out_busy;
	logic                       load_out;
	logic signed [TERM_W:0]     sum;
	logic signed [SAMPLE_W-1:0] sum_sat;

	assign in_ready = (op == OP_IDLE);
	assign start    = in_valid && (burst_length != '0);
	assign out_busy = out_valid_q && !out_ready;
	assign load_out = (op == OP_EMIT) && !out_busy;

	assign stat.start    = start;
	assign stat.div_more = div_cnt_q != DCNT_W'(1);
	assign stat.out_busy = out_busy;
	assign stat.all_ok   = fit_one && fit_two;
	assign stat.more     = burst_cnt_q != CNT_W'(1);

	dtg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	dtg_lane #(
		.AMPLITUDE (AMPLITUDE)
	) u_lane_one (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.sample_rate (sample_rate_q),
		.freq        (tone_one_q),
		.fit         (fit_one),
		.term        (term_one)
	);

	dtg_lane #(
		.AMPLITUDE (AMPLITUDE)
	) u_lane_two (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.sample_rate (sample_rate_q),
		.freq        (tone_two_q),
		.fit         (fit_two),
		.term        (term_two)
	);

	// sum of both terms, clipped to 8 bits
	always_comb begin
		sum = {term_one[TERM_W-1], term_one} + {term_two[TERM_W-1], term_two};
		if (sum > (TERM_W+1)'(127)) begin
			sum_sat = SAMPLE_W'(127);
		end else if (sum < -(TERM_W+1)'(128)) begin
			sum_sat = -SAMPLE_W'(128);
		end else begin
			sum_sat = sum[SAMPLE_W-1:0];
		end
	end

	// config writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= SAMPLE_RATE_RST;
			tone_one_q    <= TONE_ONE_RST;
			tone_two_q    <= TONE_TWO_RST;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				REG_TONE_ONE:    tone_one_q    <= cfg_data;
				REG_TONE_TWO:    tone_two_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// burst and divider step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_cnt_q <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (op == OP_IDLE && start) begin
				if (burst_length > LEN_W'(MAX_BURST)) begin
					burst_cnt_q <= CNT_W'(MAX_BURST);
				end else begin
					burst_cnt_q <= burst_length[CNT_W-1:0];
				end
			end else if (op == OP_NEXT) begin
				burst_cnt_q <= burst_cnt_q - CNT_W'(1);
			end
			unique case (op)
				OP_PER_DIV:  div_cnt_q <= DIV_STEPS_PERIOD;
				OP_TURN_DIV: div_cnt_q <= DIV_STEPS_TURN;
				OP_MOD_DIV:  div_cnt_q <= DIV_STEPS_MOD;
				OP_DIV_STEP: div_cnt_q <= div_cnt_q - DCNT_W'(1);
				default: ;
			endcase
		end
	end

	// output register, refilled in the same cycle the old sample transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_q <= sum_sat;
			last_q   <= (burst_cnt_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

endmodule

FILE: sv/dtg_checker.sv
module dtg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [dtg_pkg::LEN_W-1:0]           burst_length,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [dtg_pkg::SAMPLE_W-1:0] sample,
	input logic                                last
);

	// stalled sample holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last))
		else $error("output changed while stalled");

	// a nonzero burst, once taken, closes the input
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && burst_length != '0 |=> !in_ready)
		else $error("input open right after a burst started");

	// a pending mid-burst sample means the burst is still in flight
	a_no_take_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input open with a burst unfinished");

	a_more_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready)
		else $error("input open after a non-final transfer");

endmodule

bind dual_tone_generator dtg_checker u_dtg_checker (.*);
